// ----- hdl/fris_pkg.sv -----
package fris_pkg;

	// Default width of the byte offset counters.
	localparam int unsigned OFFSET_BITS_DEF = 40;

	// Fixed widths of the result fields.
	localparam int unsigned POS_W  = 40;
	localparam int unsigned LEN_W  = 40;
	localparam int unsigned HLEN_W = 24;
	localparam int unsigned HCNT_W = 16;
	localparam int unsigned LINE_W = 32;

	// Characters with a meaning of their own in the file format.
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_SEP = 8'h01;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// One bit per character code, eight rows of 32 codes each.
	// Row one holds '-', rows two and three hold the letters without J and j.
	localparam logic [31:0] LETTER_MASK [8] = '{
		32'h0000_0000, 32'h0000_2000, 32'h07ff_fbfe, 32'h07ff_fbfe,
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
	};

	typedef enum logic [2:0] {
		PH_START,
		PH_HEADER,
		PH_FIRST,
		PH_REST,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic {
		KIND_RECORD = 1'b0,
		KIND_ERROR  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   header_start;
		logic [HLEN_W-1:0]  header_length;
		logic [HCNT_W-1:0]  header_count;
		logic [POS_W-1:0]   sequence_start;
		logic [LEN_W-1:0]   raw_length;
		logic [LEN_W-1:0]   letter_count;
		logic [LINE_W-1:0]  line_count;
		logic [LINE_W-1:0]  line_width;
		logic [LINE_W-1:0]  last_width;
		logic               last_record;
	} record_t;

	function automatic logic is_letter(input logic [7:0] ch);
		logic [31:0] row;
		row = LETTER_MASK[ch[7:5]];
		return row[ch[4:0]];
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return (ch == CH_SP) || ((ch >= CH_TAB) && (ch <= CH_CR));
	endfunction

endpackage

// ----- hdl/fasta_record_index_scanner_core.sv -----
// FASTA record index scanner. Feed the file one byte per word on data_byte, then one
// word with end_of_file set; the block returns one descriptor word per record (header
// offset, length and 0x01-separated part count, sequence start after leading
// whitespace, raw and letter lengths, line count, common line width and last-line
// width) or a single error word, after which it stays silent until reset, as it also
// does after the record that end of file closes. Every byte is handled as it arrives
// by the state registers, so a word is accepted in every cycle unless input stalls; a
// result leaves through a two-entry output buffer, and input stalls only when both
// entries hold results that the consumer has not yet taken. Offsets count in OFFSET_BITS
// bits and, like all lengths and counts, saturate at their maximum instead of wrapping.
module fasta_record_index_scanner_core #(
	parameter int unsigned OFFSET_BITS = fris_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_file,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [fris_pkg::POS_W-1:0]    header_start,
	output logic [fris_pkg::HLEN_W-1:0]   header_length,
	output logic [fris_pkg::HCNT_W-1:0]   header_count,
	output logic [fris_pkg::POS_W-1:0]    sequence_start,
	output logic [fris_pkg::LEN_W-1:0]    raw_length,
	output logic [fris_pkg::LEN_W-1:0]    letter_count,
	output logic [fris_pkg::LINE_W-1:0]   line_count,
	output logic [fris_pkg::LINE_W-1:0]   line_width,
	output logic [fris_pkg::LINE_W-1:0]   last_width,
	output logic                          last_record
);

	// The sum that moves the sequence start must hold both an offset and a raw length.
	localparam int unsigned SUM_W =
		((OFFSET_BITS > fris_pkg::LEN_W) ? OFFSET_BITS : fris_pkg::LEN_W) + 1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	// Scanner state.
	fris_pkg::phase_t               phase_q, phase_nx;
	logic [OFFSET_BITS-1:0]         byte_offset_q, byte_offset_nx;
	logic [OFFSET_BITS-1:0]         hdr_begin_q, hdr_begin_nx;
	logic [fris_pkg::HLEN_W-1:0]    hdr_bytes_q, hdr_bytes_nx;
	logic [fris_pkg::HCNT_W-1:0]    hdr_parts_q, hdr_parts_nx;
	logic [OFFSET_BITS-1:0]         seq_begin_q, seq_begin_nx;
	logic [fris_pkg::LEN_W-1:0]     raw_bytes_q, raw_bytes_nx;
	logic [fris_pkg::LEN_W-1:0]     letters_q, letters_nx;
	logic [fris_pkg::LINE_W-1:0]    lines_q, lines_nx;
	logic [fris_pkg::LINE_W-1:0]    first_width_q, first_width_nx;
	logic [fris_pkg::LINE_W-1:0]    current_width_q, current_width_nx;
	logic                           widths_differ_q, widths_differ_nx;
	logic                           width_tracking_q, width_tracking_nx;

	// Byte decode and saturating increments.
	logic                           in_fire;
	logic                           ch_letter, ch_space, ch_nl, ch_gt, ch_sp, ch_sep;
	logic                           no_letters;
	logic                           gt_ends_record;
	logic [OFFSET_BITS-1:0]         off_inc;
	logic [fris_pkg::HLEN_W-1:0]    hdr_bytes_inc;
	logic [fris_pkg::HCNT_W-1:0]    hdr_parts_inc;
	logic [fris_pkg::LEN_W-1:0]     raw_inc, letters_inc;
	logic [fris_pkg::LINE_W-1:0]    lines_inc, first_width_inc, current_width_inc;
	logic [SUM_W-1:0]               seq_sum;
	logic [OFFSET_BITS-1:0]         seq_moved;

	// Result toward the output buffer.
	logic                           emit_valid;
	fris_pkg::record_t              emit_rec;
	fris_pkg::record_t              cur_rec;
	fris_pkg::record_t              out_rec;

	assign in_fire = in_valid && in_ready;

	assign ch_letter = fris_pkg::is_letter(data_byte);
	assign ch_space  = fris_pkg::is_space(data_byte);
	assign ch_nl     = (data_byte == fris_pkg::CH_NL);
	assign ch_gt     = (data_byte == fris_pkg::CH_GT);
	assign ch_sp     = (data_byte == fris_pkg::CH_SP);
	assign ch_sep    = (data_byte == fris_pkg::CH_SEP);

	assign no_letters = (letters_q == '0);
	// A '>' may close the record only at a line start or after width tracking stops, or once widths differ.
	assign gt_ends_record = (current_width_q == '0) || widths_differ_q;

	assign off_inc           = (&byte_offset_q)   ? byte_offset_q   : byte_offset_q + 1'b1;
	assign hdr_bytes_inc     = (&hdr_bytes_q)     ? hdr_bytes_q     : hdr_bytes_q + 1'b1;
	assign hdr_parts_inc     = (&hdr_parts_q)     ? hdr_parts_q     : hdr_parts_q + 1'b1;
	assign raw_inc           = (&raw_bytes_q)     ? raw_bytes_q     : raw_bytes_q + 1'b1;
	assign letters_inc       = (&letters_q)       ? letters_q       : letters_q + 1'b1;
	assign lines_inc         = (&lines_q)         ? lines_q         : lines_q + 1'b1;
	assign first_width_inc   = (&first_width_q)   ? first_width_q   : first_width_q + 1'b1;
	assign current_width_inc = (&current_width_q) ? current_width_q : current_width_q + 1'b1;

	// Leading whitespace moves the sequence start past everything counted so far.
	assign seq_sum   = SUM_W'(seq_begin_q) + SUM_W'(raw_inc);
	assign seq_moved = (seq_sum > SUM_W'(OFF_MAX)) ? OFF_MAX : seq_sum[OFFSET_BITS-1:0];

	// The descriptor as the state holds it now.
	always_comb begin
		cur_rec                = '0;
		cur_rec.kind           = fris_pkg::KIND_RECORD;
		cur_rec.header_start   = fris_pkg::POS_W'(hdr_begin_q);
		cur_rec.header_length  = hdr_bytes_q;
		cur_rec.header_count   = hdr_parts_q;
		cur_rec.sequence_start = fris_pkg::POS_W'(seq_begin_q);
		cur_rec.raw_length     = raw_bytes_q;
		cur_rec.letter_count   = letters_q;
		cur_rec.line_count     = lines_q;
		cur_rec.line_width     = first_width_q;
		cur_rec.last_width     = current_width_q;
		cur_rec.last_record    = 1'b0;
	end

	// Next phase.
	always_comb begin
		phase_nx = phase_q;
		if (in_fire) begin
			unique case (phase_q)
				fris_pkg::PH_START: begin
					phase_nx = (end_of_file || !ch_gt) ? fris_pkg::PH_ERROR
						: fris_pkg::PH_HEADER;
				end
				fris_pkg::PH_HEADER: begin
					if (end_of_file) begin
						phase_nx = fris_pkg::PH_ERROR;
					end else if (ch_nl) begin
						phase_nx = fris_pkg::PH_FIRST;
					end
				end
				fris_pkg::PH_FIRST: begin
					if (end_of_file) begin
						phase_nx = no_letters ? fris_pkg::PH_ERROR : fris_pkg::PH_DONE;
					end else if (!ch_letter && ch_nl && !no_letters) begin
						phase_nx = fris_pkg::PH_REST;
					end
				end
				fris_pkg::PH_REST: begin
					priority if (end_of_file) begin
						phase_nx = fris_pkg::PH_DONE;
					end else if (ch_letter || ch_nl || ch_sp) begin
						phase_nx = fris_pkg::PH_REST;
					end else if (ch_gt) begin
						phase_nx = gt_ends_record ? fris_pkg::PH_HEADER : fris_pkg::PH_ERROR;
					end else begin
						phase_nx = fris_pkg::PH_ERROR;
					end
				end
				fris_pkg::PH_DONE, fris_pkg::PH_ERROR: begin
					phase_nx = phase_q;
				end
				default: begin
					phase_nx = fris_pkg::PH_ERROR;
				end
			endcase
		end
	end

	// Counter updates and the result that a word causes.
	always_comb begin
		byte_offset_nx    = byte_offset_q;
		hdr_begin_nx      = hdr_begin_q;
		hdr_bytes_nx      = hdr_bytes_q;
		hdr_parts_nx      = hdr_parts_q;
		seq_begin_nx      = seq_begin_q;
		raw_bytes_nx      = raw_bytes_q;
		letters_nx        = letters_q;
		lines_nx          = lines_q;
		first_width_nx    = first_width_q;
		current_width_nx  = current_width_q;
		widths_differ_nx  = widths_differ_q;
		width_tracking_nx = width_tracking_q;
		emit_valid        = 1'b0;
		emit_rec          = cur_rec;

		if (in_fire && (phase_q != fris_pkg::PH_DONE) && (phase_q != fris_pkg::PH_ERROR)) begin
			if (end_of_file) begin
				emit_valid = 1'b1;
				emit_rec.last_record = 1'b1;
				priority if ((phase_q == fris_pkg::PH_FIRST) && !no_letters) begin
					lines_nx = lines_inc;
					emit_rec.line_count = lines_inc;
				end else if (phase_q == fris_pkg::PH_REST) begin
					// An unfinished last line counts only while widths still agree.
					if ((current_width_q != '0) && !widths_differ_q) begin
						lines_nx = lines_inc;
						emit_rec.line_count = lines_inc;
					end
				end else begin
					emit_rec = '0;
					emit_rec.kind = fris_pkg::KIND_ERROR;
				end
			end else begin
				byte_offset_nx = off_inc;
				unique case (phase_q)
					fris_pkg::PH_START: begin
						if (ch_gt) begin
							hdr_begin_nx = off_inc;
							hdr_bytes_nx = '0;
							hdr_parts_nx = fris_pkg::HCNT_W'(1);
						end else begin
							emit_valid    = 1'b1;
							emit_rec      = '0;
							emit_rec.kind = fris_pkg::KIND_ERROR;
						end
					end
					fris_pkg::PH_HEADER: begin
						hdr_bytes_nx = hdr_bytes_inc;
						if (ch_sep) begin
							hdr_parts_nx = hdr_parts_inc;
						end
						if (ch_nl) begin
							seq_begin_nx      = off_inc;
							raw_bytes_nx      = '0;
							letters_nx        = '0;
							lines_nx          = '0;
							first_width_nx    = '0;
							current_width_nx  = '0;
							widths_differ_nx  = 1'b0;
							width_tracking_nx = 1'b1;
						end
					end
					fris_pkg::PH_FIRST: begin
						raw_bytes_nx = raw_inc;
						if (ch_letter) begin
							first_width_nx = first_width_inc;
							letters_nx     = letters_inc;
						end else if (ch_nl && !no_letters) begin
							lines_nx = lines_inc;
						end else if (ch_space && no_letters) begin
							seq_begin_nx = seq_moved;
							raw_bytes_nx = '0;
						end
					end
					fris_pkg::PH_REST: begin
						raw_bytes_nx = raw_inc;
						priority if (ch_letter) begin
							if (width_tracking_q) begin
								if (widths_differ_q) begin
									current_width_nx  = '0;
									first_width_nx    = '0;
									width_tracking_nx = 1'b0;
									widths_differ_nx  = 1'b0;
								end else begin
									current_width_nx = current_width_inc;
								end
							end
							letters_nx = letters_inc;
						end else if (ch_nl) begin
							if (width_tracking_q) begin
								if (current_width_q != first_width_q) begin
									widths_differ_nx = 1'b1;
								end else begin
									current_width_nx = '0;
								end
							end
							lines_nx = lines_inc;
						end else if (ch_gt) begin
							emit_valid = 1'b1;
							if (gt_ends_record) begin
								// The closing '>' counts in the raw length.
								emit_rec.raw_length = raw_inc;
								hdr_begin_nx = off_inc;
								hdr_bytes_nx = '0;
								hdr_parts_nx = fris_pkg::HCNT_W'(1);
							end else begin
								emit_rec      = '0;
								emit_rec.kind = fris_pkg::KIND_ERROR;
							end
						end else if (ch_sp) begin
							if (width_tracking_q) begin
								current_width_nx  = '0;
								first_width_nx    = '0;
								width_tracking_nx = 1'b0;
								widths_differ_nx  = 1'b0;
							end
						end else begin
							emit_valid    = 1'b1;
							emit_rec      = '0;
							emit_rec.kind = fris_pkg::KIND_ERROR;
						end
					end
					default: begin
						emit_valid = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= fris_pkg::PH_START;
			byte_offset_q    <= '0;
			hdr_begin_q      <= '0;
			hdr_bytes_q      <= '0;
			hdr_parts_q      <= '0;
			seq_begin_q      <= '0;
			raw_bytes_q      <= '0;
			letters_q        <= '0;
			lines_q          <= '0;
			first_width_q    <= '0;
			current_width_q  <= '0;
			widths_differ_q  <= 1'b0;
			width_tracking_q <= 1'b1;
		end else begin
			phase_q          <= phase_nx;
			byte_offset_q    <= byte_offset_nx;
			hdr_begin_q      <= hdr_begin_nx;
			hdr_bytes_q      <= hdr_bytes_nx;
			hdr_parts_q      <= hdr_parts_nx;
			seq_begin_q      <= seq_begin_nx;
			raw_bytes_q      <= raw_bytes_nx;
			letters_q        <= letters_nx;
			lines_q          <= lines_nx;
			first_width_q    <= first_width_nx;
			current_width_q  <= current_width_nx;
			widths_differ_q  <= widths_differ_nx;
			width_tracking_q <= width_tracking_nx;
		end
	end

	// Two-entry output buffer: the scanner keeps taking bytes while a result waits.
	fris_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (emit_valid),
		.in_ready  (in_ready),
		.in_data   (emit_rec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_rec)
	);

	assign result_kind    = out_rec.kind;
	assign header_start   = out_rec.header_start;
	assign header_length  = out_rec.header_length;
	assign header_count   = out_rec.header_count;
	assign sequence_start = out_rec.sequence_start;
	assign raw_length     = out_rec.raw_length;
	assign letter_count   = out_rec.letter_count;
	assign line_count     = out_rec.line_count;
	assign line_width     = out_rec.line_width;
	assign last_width     = out_rec.last_width;
	assign last_record    = out_rec.last_record;

	// An error word leaving the block means the scanner has already locked up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && result_kind) |-> (phase_q == fris_pkg::PH_ERROR))
	else $error("error word delivered while the scanner is not in its error phase");

	// An error word carries nothing but its kind.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind) |-> ((header_start == '0) && (raw_length == '0)
			&& (letter_count == '0) && (line_count == '0) && !last_record))
	else $error("error word carries descriptor fields");

	// The buffer refuses words only when both of its entries are full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
	else $error("input stalled with an empty output register");

	// After the last record or an error, words change nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && ((phase_q == fris_pkg::PH_DONE) || (phase_q == fris_pkg::PH_ERROR)))
		|=> ($stable(byte_offset_q) && $stable(phase_q)))
	else $error("scanner state moved after the end of the scan");

endmodule

// ----- hdl/fris_skid.sv -----
module fris_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fris_pkg::record_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fris_pkg::record_t  out_data
);

	logic               main_valid_q;
	logic               skid_valid_q;
	fris_pkg::record_t  main_q;
	fris_pkg::record_t  skid_q;
	logic               in_fire;
	logic               main_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign main_free = out_ready || !main_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule
